// ----- rtl/sbb_pkg.sv -----
// Shared types, widths and codes for the spatial block binning block.
// Used by sbb_locate and spatial_block_binning; depends on nothing.
package sbb_pkg;

  // Geometry of the grid and the buckets
  localparam int BLOCK_WIDTH       = 32;
  localparam int GRID_BLOCKS       = 32;
  localparam int BUCKET_DEPTH      = 8;
  localparam int REGION_WIDTH      = 8;
  localparam int MARGIN_WIDTH      = 12;
  localparam int OBJECT_INDEX_BITS = 17;

  localparam int BLOCK_SHIFT = $clog2(BLOCK_WIDTH);
  localparam int GRID_BITS   = $clog2(GRID_BLOCKS);
  localparam int NBLOCKS     = GRID_BLOCKS * GRID_BLOCKS;
  localparam int SLOT_BITS   = $clog2(BUCKET_DEPTH);

  // Field widths
  localparam int ACT_W  = 2;
  localparam int IDX_W  = OBJECT_INDEX_BITS;
  localparam int POS_W  = 11;
  localparam int BLK_W  = 10;
  localparam int OFS_W  = 5;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 4;

  // Shifted coordinate: position minus offset minus half a block, signed
  localparam int CO_W = POS_W + 2;

  localparam int SLOT_ADDR_W = BLK_W + SLOT_BITS;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 32;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_PLACED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_OUTSIDE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STAT_W-1:0] ST_READ_ENTRY = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ_EMPTY = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED    = 3'd5;

  // Configuration register indexes
  localparam logic REG_MESH_OFFSET_X = 1'b0;
  localparam logic REG_MESH_OFFSET_Y = 1'b1;

  // Block lookup result
  typedef struct packed {
    logic             in_area;
    logic [BLK_W-1:0] block;
  } loc_t;

  // One result item
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  block_num;
    logic [IDX_W-1:0]  entry_index;
    logic [CNT_W-1:0]  bucket_count;
    logic              last;
  } result_t;

endpackage

// ----- rtl/sbb_locate.sv -----
// Position to block lookup: mesh shift, block split and proposal region test.
// Depends on sbb_pkg.
module sbb_locate (
  input  logic                               [sbb_pkg::POS_W-1:0] pos_x,
  input  logic                               [sbb_pkg::POS_W-1:0] pos_y,
  input  logic signed                        [sbb_pkg::OFS_W-1:0] mesh_offset_x,
  input  logic signed                        [sbb_pkg::OFS_W-1:0] mesh_offset_y,
  output sbb_pkg::loc_t                                           loc
);

  localparam int CO_W  = sbb_pkg::CO_W;
  localparam int BS    = sbb_pkg::BLOCK_SHIFT;
  localparam int BC_W  = CO_W - 1 - BS;
  localparam logic signed [CO_W-1:0] HALF_CO = CO_W'(sbb_pkg::BLOCK_WIDTH / 2);

  logic signed [CO_W-1:0] x;
  logic signed [CO_W-1:0] y;
  logic [BC_W-1:0]        bx;
  logic [BC_W-1:0]        by;
  logic [BS-1:0]          xi;
  logic [BS-1:0]          yi;

  function automatic logic in_region(input logic [BS-1:0] c);
    return (int'(c) >= sbb_pkg::MARGIN_WIDTH) &&
           (int'(c) < sbb_pkg::MARGIN_WIDTH + sbb_pkg::REGION_WIDTH);
  endfunction

  // Shift the position by the mesh offset and half a block
  assign x = $signed(CO_W'(pos_x)) - CO_W'(mesh_offset_x) - HALF_CO;
  assign y = $signed(CO_W'(pos_y)) - CO_W'(mesh_offset_y) - HALF_CO;

  // Block coordinate and in-block coordinate (valid when non-negative)
  assign bx = x[CO_W-2:BS];
  assign by = y[CO_W-2:BS];
  assign xi = x[BS-1:0];
  assign yi = y[BS-1:0];

  // Accept only inside the grid and inside the central region
  assign loc.in_area = !x[CO_W-1] && !y[CO_W-1] && in_region(xi) && in_region(yi) &&
                       (int'(bx) < sbb_pkg::GRID_BLOCKS) &&
                       (int'(by) < sbb_pkg::GRID_BLOCKS);
  assign loc.block   = sbb_pkg::BLK_W'({bx[sbb_pkg::GRID_BITS-1:0],
                                        by[sbb_pkg::GRID_BITS-1:0]});

endmodule

// ----- rtl/sbb_ram.sv -----
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// No dependencies; holds bucket counts and bucket slots in the top level.
module sbb_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/spatial_block_binning.sv -----
// Spatial block binning: sorts objects into per-block buckets and lists them.
// Depends on sbb_pkg, sbb_locate and sbb_ram.
//
// Input stream s_*: s_tuser carries the action (insert, read, clear), s_tdata
// the object index, position and block to read. Output stream m_*: m_tuser is
// the status, m_tdata block id, entry index and bucket count, m_tlast marks
// the final result of an input transaction.
// Configuration: cfg_wr_en writes cfg_data into mesh offset x (index 0) or
// y (index 1); write only while the block is idle.
// Operation: one item at a time. An insert reads the count RAM; once the output
// register is free it loads its result there and, if the object is in the area
// and the bucket is not full, writes the slot and count. A read looks up the
// count, then lists each entry with a slot RAM read followed by an output load.
// A clear emits its result and then sweeps all 1024 count RAM entries, one entry
// per cycle, before the next transaction.
// Reset: config registers go to zero and the same count sweep runs with
// s_tready low. A stalled receiver holds the output register; the block then
// waits with its RAM read data held and loses nothing.
module spatial_block_binning (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port
  input  logic                             cfg_wr_en,
  input  logic                             cfg_index,
  input  logic [sbb_pkg::OFS_W-1:0]        cfg_data,
  // Input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sbb_pkg::IN_DATA_W-1:0]    s_tdata,   // object_index, pos_x, pos_y, read_block
  input  logic [sbb_pkg::ACT_W-1:0]        s_tuser,   // action
  // Output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sbb_pkg::OUT_DATA_W-1:0]   m_tdata,   // block number, entry_index, bucket_count
  output logic [sbb_pkg::STAT_W-1:0]       m_tuser,   // status
  output logic                             m_tlast
);

  localparam int BLK_W = sbb_pkg::BLK_W;
  localparam int IDX_W = sbb_pkg::IDX_W;
  localparam int POS_W = sbb_pkg::POS_W;
  localparam int CNT_W = sbb_pkg::CNT_W;
  localparam int SB    = sbb_pkg::SLOT_BITS;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(sbb_pkg::BUCKET_DEPTH);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_INS,
    S_RD_CNT,
    S_RD_ISSUE,
    S_RD_DATA,
    S_CLR_RES
  } state_t;

  state_t state;

  logic signed [sbb_pkg::OFS_W-1:0] mesh_offset_x;
  logic signed [sbb_pkg::OFS_W-1:0] mesh_offset_y;

  logic [BLK_W-1:0]  sweep_addr;
  logic [BLK_W-1:0]  op_block;
  logic              op_in_area;
  logic [IDX_W-1:0]  op_obj;
  logic              rd_oor;
  logic [SB-1:0]     rd_k;
  logic [CNT_W-1:0]  rd_n;
  logic              out_valid;
  sbb_pkg::result_t  out_res;

  // Unpacked input fields
  logic [IDX_W-1:0] in_obj;
  logic [POS_W-1:0] in_pos_x;
  logic [POS_W-1:0] in_pos_y;
  logic [BLK_W-1:0] in_read_block;
  sbb_pkg::loc_t    loc;

  logic accept;
  logic out_free;
  logic out_load;
  logic full;
  logic ins_write;

  // Count RAM ports
  logic             cnt_we;
  logic [BLK_W-1:0] cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic [BLK_W-1:0] cnt_raddr;
  logic [CNT_W-1:0] cnt_rdata;

  // Slot RAM ports
  logic                            slot_re;
  logic [sbb_pkg::SLOT_ADDR_W-1:0] slot_waddr;
  logic [sbb_pkg::SLOT_ADDR_W-1:0] slot_raddr;
  logic [IDX_W-1:0]                slot_rdata;

  assign in_obj        = s_tdata[IDX_W-1:0];
  assign in_pos_x      = s_tdata[IDX_W +: POS_W];
  assign in_pos_y      = s_tdata[IDX_W + POS_W +: POS_W];
  assign in_read_block = s_tdata[IDX_W + 2*POS_W +: BLK_W];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_offset_x <= '0;
      mesh_offset_y <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sbb_pkg::REG_MESH_OFFSET_X: mesh_offset_x <= cfg_data;
        sbb_pkg::REG_MESH_OFFSET_Y: mesh_offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  sbb_locate u_locate (
    .pos_x         (in_pos_x),
    .pos_y         (in_pos_y),
    .mesh_offset_x (mesh_offset_x),
    .mesh_offset_y (mesh_offset_y),
    .loc           (loc)
  );

  // Handshake
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // Output register is loaded this cycle
  assign out_load = (state == S_RD_DATA) ||
                    (out_free && ((state == S_INS) || (state == S_CLR_RES) ||
                                  ((state == S_RD_CNT) && (rd_oor || (cnt_rdata == '0)))));

  // Insert decision from the count read back
  assign full      = (cnt_rdata >= DEPTH_CNT);
  assign ins_write = (state == S_INS) && out_free && op_in_area && !full;

  // Count RAM: looked up on every acceptance, written by inserts and sweeps
  assign cnt_raddr = (s_tuser == sbb_pkg::ACT_READ) ? in_read_block : loc.block;
  assign cnt_we    = (state == S_SWEEP) || ins_write;
  assign cnt_waddr = (state == S_SWEEP) ? sweep_addr : op_block;
  assign cnt_wdata = (state == S_SWEEP) ? '0 : cnt_rdata + CNT_W'(1);

  sbb_ram #(
    .ADDR_W (BLK_W),
    .DATA_W (CNT_W)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (accept),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Slot RAM: appended by inserts, listed by reads
  assign slot_waddr = {op_block, cnt_rdata[SB-1:0]};
  assign slot_re    = (state == S_RD_ISSUE) && out_free;
  assign slot_raddr = {op_block, rd_k};

  sbb_ram #(
    .ADDR_W (sbb_pkg::SLOT_ADDR_W),
    .DATA_W (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ins_write),
    .waddr (slot_waddr),
    .wdata (op_obj),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && m_tready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + BLK_W'(1);
          if (sweep_addr == BLK_W'(sbb_pkg::NBLOCKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_block   <= (s_tuser == sbb_pkg::ACT_READ) ? in_read_block : loc.block;
            op_in_area <= loc.in_area;
            op_obj     <= in_obj;
            rd_oor     <= (int'(in_read_block) >= sbb_pkg::NBLOCKS);
            case (s_tuser)
              sbb_pkg::ACT_INSERT: state <= S_INS;
              sbb_pkg::ACT_READ:   state <= S_RD_CNT;
              sbb_pkg::ACT_CLEAR:  state <= S_CLR_RES;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_INS: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (!op_in_area) begin
              out_res <= '{sbb_pkg::ST_OUTSIDE, '0, '0, '0, 1'b1};
            end else if (full) begin
              out_res <= '{sbb_pkg::ST_FULL, op_block, '0, DEPTH_CNT, 1'b1};
            end else begin
              out_res <= '{sbb_pkg::ST_PLACED, op_block, '0, cnt_wdata, 1'b1};
            end
            state <= S_IDLE;
          end
        end
        S_RD_CNT: begin
          if (rd_oor || (cnt_rdata == '0)) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_res   <= '{sbb_pkg::ST_READ_EMPTY, op_block, '0, '0, 1'b1};
              state     <= S_IDLE;
            end
          end else begin
            rd_n  <= full ? DEPTH_CNT : cnt_rdata;
            rd_k  <= '0;
            state <= S_RD_ISSUE;
          end
        end
        S_RD_ISSUE: begin
          if (out_free) begin
            state <= S_RD_DATA;
          end
        end
        S_RD_DATA: begin
          out_valid <= 1'b1;
          out_res   <= '{sbb_pkg::ST_READ_ENTRY, op_block, slot_rdata, rd_n,
                         (CNT_W'(rd_k) + CNT_W'(1)) == rd_n};
          rd_k      <= rd_k + SB'(1);
          if ((CNT_W'(rd_k) + CNT_W'(1)) == rd_n) begin
            state <= S_IDLE;
          end else begin
            state <= S_RD_ISSUE;
          end
        end
        S_CLR_RES: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_res    <= '{sbb_pkg::ST_CLEARED, '0, '0, '0, 1'b1};
            sweep_addr <= '0;
            state      <= S_SWEEP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output stream
  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tlast  = out_res.last;
  assign m_tdata  = sbb_pkg::OUT_DATA_W'({out_res.bucket_count, out_res.entry_index,
                                          out_res.block_num});

  // A count written by an insert stays within the bucket depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ins_write |-> (cnt_wdata != '0) && (cnt_wdata <= DEPTH_CNT))
    else $error("bucket count write out of range");

  // A slot read only targets entries below the bucket's count
  a_slot_in_count: assert property (@(posedge clk) disable iff (rst)
    slot_re |-> (CNT_W'(rd_k) < rd_n))
    else $error("slot read beyond bucket count");

  // The output register is free when slot data arrives
  a_out_free_on_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_DATA) |-> !out_valid)
    else $error("read entry would overwrite a pending result");

  // Listing only runs for a bucket in the grid with entries
  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RD_ISSUE) || (state == S_RD_DATA)) |-> !rd_oor && (rd_n != '0))
    else $error("listing an empty or out-of-grid bucket");

  // A clear is followed by a sweep from the first entry
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR_RES) && out_free |=> (state == S_SWEEP) && (sweep_addr == '0))
    else $error("clear did not start a sweep");

endmodule
